// File: hdl/slrg_pkg.sv
// Shared types, constants and controller codes for the shuffled Lehmer generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package slrg_pkg;

  // Lehmer generator constants
  localparam logic [14:0] LEH_A    = 15'd16807;
  localparam logic [30:0] LEH_M    = 31'h7FFF_FFFF;
  localparam logic [23:0] FRAC_CAP = 24'd16777214;

  // Default depth of the shuffle table
  localparam int TABLE_SIZE_DEF = 32;

  // Request item
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] seed_value;
  } slrg_req_t;

  // Response item
  typedef struct packed {
    logic [30:0] random_int;
    logic [23:0] random_fraction;
    logic [30:0] state_now;
    logic        did_warmup;
  } slrg_rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WMUL,
    ST_WRED,
    ST_DMUL,
    ST_DRED,
    ST_SLOT,
    ST_OUT
  } slrg_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;      // take request item, pick working state
    logic step_mul;   // multiply working state by 16807
    logic warm_red;   // reduce product, fill a table entry
    logic div_load;   // register slot index from last output
    logic draw_red;   // reduce product, update Lehmer state
    logic tbl_read;   // read table entry at slot
    logic finish;     // rewrite slot, load response register
  } slrg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_warm; // the request item needs a table refill
    logic cnt_zero;   // last warm-up step
    logic out_free;   // response register can take an item
  } slrg_status_t;

endpackage

`default_nettype wire

// File: hdl/slrg_ctrl.sv
// Controller state machine for the shuffled Lehmer generator.
// Depends on slrg_pkg; drives slrg_datapath through command and status structs.
`default_nettype none

module slrg_ctrl
  import slrg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire slrg_status_t status,
  output slrg_cmd_t         cmd
);

  slrg_state_t state;
  slrg_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = status.start_warm ? ST_WMUL : ST_DMUL;
        end
      end
      ST_WMUL: begin
        cmd.step_mul = 1'b1;
        state_next   = ST_WRED;
      end
      ST_WRED: begin
        cmd.warm_red = 1'b1;
        state_next   = status.cnt_zero ? ST_DMUL : ST_WMUL;
      end
      ST_DMUL: begin
        cmd.step_mul = 1'b1;
        cmd.div_load = 1'b1;
        state_next   = ST_DRED;
      end
      ST_DRED: begin
        cmd.draw_red = 1'b1;
        state_next   = ST_SLOT;
      end
      ST_SLOT: begin
        cmd.tbl_read = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // One item in flight at a time
  assign req_stall = (state != ST_IDLE);

endmodule

`default_nettype wire

// File: hdl/slrg_datapath.sv
// Datapath: Lehmer step unit, slot index unit, shuffle table and response register.
// Depends on slrg_pkg; sequenced by slrg_ctrl.
`default_nettype none

module slrg_datapath
  import slrg_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire slrg_req_t req,
  input  wire slrg_cmd_t cmd,
  output slrg_status_t   status,
  output slrg_rsp_t      rsp,
  output logic           rsp_valid,
  input  wire logic      rsp_stall
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int CW  = $clog2(TABLE_SIZE + 8);
  localparam longint SLOT_DIV = 1 + (longint'(LEH_M) - 1) / TABLE_SIZE;

  logic [30:0]        lehmer_state;
  logic [30:0]        last_output;
  logic [31:0]        s;
  logic [46:0]        prod;
  logic [CW-1:0]      cnt;
  logic               warm_q;
  logic [IW-1:0]      slot;
  logic [IW-1:0]      slot_q;
  logic [30:0]        rd_data;
  logic [30:0]        tbl [TABLE_SIZE];

  logic signed [31:0] s_sel;
  logic [31:0]        s_neg;
  logic [31:0]        s_load;
  logic               start_warm;
  logic [31:0]        sum;
  logic [30:0]        red;
  logic [IW-1:0]      slot_calc;
  logic [23:0]        frac_a;
  logic [31:0]        frac_ab;
  logic [24:0]        frac_raw;
  logic [23:0]        frac;

  // Working state for the request item; refill when not positive or table empty
  assign s_sel      = req.cmd ? req.seed_value : $signed({1'b0, lehmer_state});
  assign s_neg      = ~s_sel + 32'd1;
  assign start_warm = (s_sel <= 32'sd0) || (last_output == '0);
  assign s_load     = start_warm ? (s_sel[31] ? s_neg : 32'd1) : $unsigned(s_sel);

  // Reduction mod 2^31-1: fold high bits onto low, one conditional subtract
  assign sum = {16'd0, prod[46:31]} + {1'b0, prod[30:0]};
  assign red = (sum >= {1'b0, LEH_M}) ? 31'(sum - {1'b0, LEH_M}) : sum[30:0];

  // Slot: highest k with last output >= k * SLOT_DIV, so never past the table end
  always_comb begin
    slot_calc = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if ({1'b0, last_output} >= 32'(longint'(k) * SLOT_DIV)) begin
        slot_calc = IW'(k);
      end
    end
  end

  // Fraction floor(x*2^24 / (2^31-1)) = (x>>7) + carry of the folded remainder
  assign frac_a   = rd_data[30:7];
  assign frac_ab  = {8'd0, frac_a} + {1'b0, rd_data[6:0], 24'd0};
  assign frac_raw = {1'b0, frac_a} + {24'd0, (frac_ab >= {1'b0, LEH_M})};
  assign frac     = (frac_raw > {1'b0, FRAC_CAP}) ? FRAC_CAP : frac_raw[23:0];

  // Generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      lehmer_state <= '0;
      last_output  <= '0;
    end else begin
      if (cmd.draw_red) begin
        lehmer_state <= red;
      end
      if (cmd.warm_red && cnt == '0) begin
        last_output <= red;
      end else if (cmd.finish) begin
        last_output <= rd_data;
      end
    end
  end

  // Working state, product and warm-up count
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s      <= s_load;
      warm_q <= start_warm;
      cnt    <= CW'(TABLE_SIZE + 7);
    end else if (cmd.warm_red || cmd.draw_red) begin
      s <= {1'b0, red};
    end
    if (cmd.warm_red) begin
      cnt <= cnt - CW'(1);
    end
    if (cmd.step_mul) begin
      prod <= {15'd0, s} * {32'd0, LEH_A};
    end
  end

  // Slot index register, taken from the previous output
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      slot <= slot_calc;
    end
  end

  // Shuffle table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.warm_red && cnt < CW'(TABLE_SIZE)) begin
      tbl[cnt[IW-1:0]] <= red;
    end else if (cmd.finish) begin
      tbl[slot_q] <= s[30:0];
    end
    if (cmd.tbl_read) begin
      rd_data <= tbl[slot];
      slot_q  <= slot;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.random_int      <= rd_data;
      rsp.random_fraction <= frac;
      rsp.state_now       <= lehmer_state;
      rsp.did_warmup      <= warm_q;
    end
  end

  // Status to the controller
  assign status.start_warm = start_warm;
  assign status.cnt_zero   = (cnt == '0);
  assign status.out_free   = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

// File: hdl/shuffled_lehmer_random_generator.sv
// Top level of the shuffled Lehmer random generator (minimal standard with shuffle).
// Depends on slrg_pkg, slrg_ctrl and slrg_datapath.
//
//   channel  handshake            payload      direction
//   req      req_valid/req_stall  slrg_req_t   in   (cmd, seed_value)
//   rsp      rsp_valid/rsp_stall  slrg_rsp_t   out  (random_int, fraction, state, warm-up)
//
// A draw runs multiply, fold, table read and response load, then returns to the
// idle state that takes the next item.
// A table refill first runs warm-up Lehmer steps, each a multiply then a fold.
// Reset (rst, synchronous) marks the generator unseeded; the table itself is not cleared.
// A new item is taken while a response still waits; a stalled response holds the
// datapath in its last state only when the next response is ready.
`default_nettype none

module shuffled_lehmer_random_generator
  import slrg_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire slrg_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output slrg_rsp_t      rsp
);

  slrg_cmd_t    cmd;
  slrg_status_t status;

  slrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  slrg_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // Once an item is taken, req_stall must rise
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while an item is in progress");

  // A new response appears only at the end of an item's work
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response raised without an item in progress");

  // A new response's fraction does not exceed the cap
  a_frac_cap: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> (rsp.random_fraction <= FRAC_CAP))
    else $error("fraction above cap");

endmodule

`default_nettype wire
